/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top level RTL module of the vertex weld block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* hw/rtl/vwr_pkg.sv */
// Shared constants, codes and types of the vertex weld block.
package vwr_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int COORD_BITS   = 24;

    localparam int VIDX_W   = $clog2(MAX_VERTICES);
    localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
    localparam int POS_W    = 3 * COORD_BITS;
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int TOL_W    = 52;
    localparam int CMP_W    = (SUM_W > TOL_W) ? SUM_W : TOL_W;
    localparam int CORNER_W = 32;
    localparam int OUT_IDX_W = 10;
    localparam int OPCODE_W = 2;
    localparam int KIND_W   = 2;

    localparam int IN_DATA_W  = ((POS_W + 3 * CORNER_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + 2 * OUT_IDX_W + 3 * CORNER_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START    = 2'd0,
        OP_VERTEX   = 2'd1,
        OP_TRIANGLE = 2'd2
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_VERTEX   = 2'd0,
        KIND_TRIANGLE = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    typedef struct packed {
        logic              valid;
        logic [VIDX_W-1:0] idx;
    } probe_tag_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [VIDX_W-1:0] idx;
    } dist_res_t;

endpackage

/* hw/rtl/vertex_weld_remap.sv */
// Top level of the vertex weld block: sequencer, vertex tables and output register.
//
// A group start item clears the vertex and kept counts. A vertex reads the kept vertices
// one per cycle from the position memory into the distance pipeline and stops at the
// first match. A vertex in an empty group skips the scan, and an overflowing vertex goes
// straight to the output with an overflow result. A triangle reads its three corners
// through the single read port of the index map and gives no output when it is dropped.
// A finished result waits in S_OUT while the output register holds a word that m_tready
// has not yet taken. The block takes one item at a time, and a finished word waits in
// the output register while the next item is already accepted.
`include "assert_macros.svh"

module vertex_weld_remap (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vwr_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: opcode
    input  logic [vwr_pkg::OPCODE_W-1:0]    s_tuser,
    // m_tdata: is_new_vertex, source_index, welded_index,
    //          out_corner_a, out_corner_b, out_corner_c, zero fill
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vwr_pkg::OUT_DATA_W-1:0]  m_tdata,
    // m_tuser: result_kind
    output logic [vwr_pkg::KIND_W-1:0]      m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vwr_pkg::TOL_W-1:0]       cfg_data
);
    import vwr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,
        S_VFIN    = 6'b000100,
        S_TRI     = 6'b001000,
        S_TRI_CHK = 6'b010000,
        S_OUT     = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [TOL_W-1:0]    tol_reg;
    logic [CNT_W-1:0]    vertex_count_reg, vertex_count_next;
    logic [CNT_W-1:0]    kept_count_reg, kept_count_next;
    logic [CNT_W-1:0]    issue_cnt_reg, issue_cnt_next;
    probe_tag_t          tag_reg, tag_next;
    logic                found_reg, found_next;
    logic [VIDX_W-1:0]   found_idx_reg, found_idx_next;
    logic [1:0]          tri_step_reg, tri_step_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [POS_W-1:0]    probe_reg, probe_next;
    logic [CORNER_W-1:0] corner_reg [3];
    logic [CORNER_W-1:0] corner_next [3];
    logic [CORNER_W-1:0] rem_reg [3];
    logic [CORNER_W-1:0] rem_next [3];
    kind_t               res_kind_reg, res_kind_next;
    logic [OUT_DATA_W-1:0] res_data_reg, res_data_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    kind_t               m_tuser_reg, m_tuser_next;

    logic                in_accept;
    logic                out_free;
    logic                scan_issue;
    logic                hit_evt;
    logic                miss_last;
    logic [VIDX_W-1:0]   last_idx;
    logic [VIDX_W-1:0]   welded;
    logic [2:0]          in_range;
    logic [1:0]          cap_idx;
    logic                tri_rd_en;
    logic [VIDX_W-1:0]   tri_rd_addr;
    logic [POS_W-1:0]    kept_rd_data;
    logic [VIDX_W-1:0]   map_rd_data;
    dist_res_t           dist_res;

    function automatic logic [OUT_DATA_W-1:0] pack_out(
        input logic                is_new,
        input logic [OUT_IDX_W-1:0] src,
        input logic [OUT_IDX_W-1:0] wld,
        input logic [CORNER_W-1:0] ca,
        input logic [CORNER_W-1:0] cb,
        input logic [CORNER_W-1:0] cc
    );
        logic [OUT_DATA_W-1:0] w;
        w = '0;
        w[0] = is_new;
        w[1 +: OUT_IDX_W] = src;
        w[1 + OUT_IDX_W +: OUT_IDX_W] = wld;
        w[1 + 2*OUT_IDX_W +: CORNER_W] = ca;
        w[1 + 2*OUT_IDX_W + CORNER_W +: CORNER_W] = cb;
        w[1 + 2*OUT_IDX_W + 2*CORNER_W +: CORNER_W] = cc;
        return w;
    endfunction

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign scan_issue = (state_reg == S_SCAN) && (issue_cnt_reg < kept_count_reg);
    assign last_idx   = VIDX_W'(kept_count_reg - CNT_W'(1));
    assign hit_evt    = (state_reg == S_SCAN) && dist_res.valid && dist_res.hit;
    assign miss_last  = (state_reg == S_SCAN) && dist_res.valid && !dist_res.hit
                        && (dist_res.idx == last_idx);
    assign welded     = found_reg ? found_idx_reg : VIDX_W'(kept_count_reg);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            in_range[k] = corner_reg[k] < CORNER_W'(vertex_count_reg);
        end
    end

    assign cap_idx   = tri_step_reg - 2'd1;
    assign tri_rd_en = (state_reg == S_TRI) && (tri_step_reg != 2'd3);

    always_comb
    begin
        case (tri_step_reg)
            2'd0:    tri_rd_addr = corner_reg[0][VIDX_W-1:0];
            2'd1:    tri_rd_addr = corner_reg[1][VIDX_W-1:0];
            default: tri_rd_addr = corner_reg[2][VIDX_W-1:0];
        endcase
    end

    vwr_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_VERTICES)
    ) u_kept_ram (
        .clk     (clk),
        .wr_en   ((state_reg == S_VFIN) && !found_reg),
        .wr_addr (VIDX_W'(kept_count_reg)),
        .wr_data (probe_reg),
        .rd_en   (scan_issue),
        .rd_addr (issue_cnt_reg[VIDX_W-1:0]),
        .rd_data (kept_rd_data)
    );

    vwr_ram #(
        .WIDTH (VIDX_W),
        .DEPTH (MAX_VERTICES)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (state_reg == S_VFIN),
        .wr_addr (VIDX_W'(vertex_count_reg)),
        .wr_data (welded),
        .rd_en   (tri_rd_en),
        .rd_addr (tri_rd_addr),
        .rd_data (map_rd_data)
    );

    vwr_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .probe     (probe_reg),
        .kept      (kept_rd_data),
        .tag       (tag_reg),
        .kill      (hit_evt),
        .tolerance (tol_reg),
        .res       (dist_res)
    );

    always_comb
    begin
        state_next        = state_reg;
        vertex_count_next = vertex_count_reg;
        kept_count_next   = kept_count_reg;
        issue_cnt_next    = issue_cnt_reg;
        found_next        = found_reg;
        found_idx_next    = found_idx_reg;
        tri_step_next     = tri_step_reg;
        probe_next        = probe_reg;
        corner_next       = corner_reg;
        rem_next          = rem_reg;
        res_kind_next     = res_kind_reg;
        res_data_next     = res_data_reg;

        tag_next.valid = scan_issue && !hit_evt;
        tag_next.idx   = issue_cnt_reg[VIDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (s_tuser)
                        OP_START:
                        begin
                            vertex_count_next = '0;
                            kept_count_next   = '0;
                        end
                        OP_VERTEX:
                        begin
                            if (vertex_count_reg == CNT_W'(MAX_VERTICES))
                            begin
                                res_kind_next = KIND_OVERFLOW;
                                res_data_next = '0;
                                state_next    = S_OUT;
                            end
                            else
                            begin
                                probe_next     = s_tdata[POS_W-1:0];
                                found_next     = 1'b0;
                                issue_cnt_next = '0;
                                state_next     = (kept_count_reg == '0) ? S_VFIN : S_SCAN;
                            end
                        end
                        OP_TRIANGLE:
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                corner_next[k] = s_tdata[POS_W + k*CORNER_W +: CORNER_W];
                            end
                            tri_step_next = 2'd0;
                            state_next    = S_TRI;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_issue)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (hit_evt)
                begin
                    found_next     = 1'b1;
                    found_idx_next = dist_res.idx;
                    state_next     = S_VFIN;
                end
                else if (miss_last)
                begin
                    state_next = S_VFIN;
                end
            end
            S_VFIN:
            begin
                res_kind_next = KIND_VERTEX;
                res_data_next = pack_out(!found_reg, OUT_IDX_W'(vertex_count_reg),
                                         OUT_IDX_W'(welded), '0, '0, '0);
                vertex_count_next = vertex_count_reg + CNT_W'(1);
                if (!found_reg)
                begin
                    kept_count_next = kept_count_reg + CNT_W'(1);
                end
                state_next = S_OUT;
            end
            S_TRI:
            begin
                tri_step_next = tri_step_reg + 2'd1;
                if (tri_step_reg != 2'd0)
                begin
                    rem_next[cap_idx] = in_range[cap_idx] ? CORNER_W'(map_rd_data)
                                                          : corner_reg[cap_idx];
                end
                if (tri_step_reg == 2'd3)
                begin
                    state_next = S_TRI_CHK;
                end
            end
            S_TRI_CHK:
            begin
                if ((rem_reg[0] == rem_reg[1]) || (rem_reg[1] == rem_reg[2])
                    || (rem_reg[0] == rem_reg[2]))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    res_kind_next = KIND_TRIANGLE;
                    res_data_next = pack_out(1'b0, '0, '0, rem_reg[0], rem_reg[1], rem_reg[2]);
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if ((state_reg == S_OUT) && out_free)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res_data_reg;
            m_tuser_next  = res_kind_reg;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tol_reg          <= '0;
            vertex_count_reg <= '0;
            kept_count_reg   <= '0;
            issue_cnt_reg    <= '0;
            tag_reg          <= '0;
            found_reg        <= 1'b0;
            tri_step_reg     <= 2'd0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            vertex_count_reg <= vertex_count_next;
            kept_count_reg   <= kept_count_next;
            issue_cnt_reg    <= issue_cnt_next;
            tag_reg          <= tag_next;
            found_reg        <= found_next;
            tri_step_reg     <= tri_step_next;
            m_tvalid_reg     <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_idx_reg <= found_idx_next;
        probe_reg     <= probe_next;
        corner_reg    <= corner_next;
        rem_reg       <= rem_next;
        res_kind_reg  <= res_kind_next;
        res_data_reg  <= res_data_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_ALWAYS(a_kept_le_seen, clk, rst_n, kept_count_reg <= vertex_count_reg,
        "kept count exceeds vertex count")
    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, vertex_count_reg <= CNT_W'(MAX_VERTICES),
        "vertex count beyond table depth")
    `ASSERT_IMPLIES(a_dist_only_scan, clk, rst_n, dist_res.valid, state_reg == S_SCAN,
        "distance result outside a scan")
    `ASSERT_IMPLIES(a_found_kept, clk, rst_n, (state_reg == S_VFIN) && found_reg,
        CNT_W'(found_idx_reg) < kept_count_reg, "match index not a kept vertex")
    `ASSERT_NEXT(a_vfin_count, clk, rst_n, state_reg == S_VFIN,
        vertex_count_reg == $past(vertex_count_reg) + CNT_W'(1), "vertex count not advanced")

endmodule

/* hw/rtl/vwr_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module vwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/vwr_dist.sv */
// Pipelined squared-distance compare of the probe vertex against one kept vertex per cycle.
module vwr_dist (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [vwr_pkg::POS_W-1:0]  probe,
    input  logic [vwr_pkg::POS_W-1:0]  kept,
    input  vwr_pkg::probe_tag_t        tag,
    input  logic                       kill,
    input  logic [vwr_pkg::TOL_W-1:0]  tolerance,
    output vwr_pkg::dist_res_t         res
);
    import vwr_pkg::*;

    logic [DIFF_W-1:0] mag_reg  [3];
    logic [DIFF_W-1:0] mag_next [3];
    logic [SQ_W-1:0]   sq_reg   [3];
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic [VIDX_W-1:0] s1_idx_reg;
    logic [VIDX_W-1:0] s2_idx_reg;
    dist_res_t         res_reg;
    dist_res_t         res_next;
    logic [SUM_W-1:0]  sum;

    always_comb
    begin
        logic signed [DIFF_W-1:0] da;
        logic signed [DIFF_W-1:0] db;
        logic signed [DIFF_W-1:0] d;
        for (int k = 0; k < 3; k++)
        begin
            da = {probe[k*COORD_BITS+COORD_BITS-1], probe[k*COORD_BITS +: COORD_BITS]};
            db = {kept[k*COORD_BITS+COORD_BITS-1], kept[k*COORD_BITS +: COORD_BITS]};
            d  = da - db;
            mag_next[k] = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        end
    end

    assign sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    always_comb
    begin
        res_next.valid = s2_valid_reg && !kill;
        res_next.hit   = CMP_W'(sum) <= CMP_W'(tolerance);
        res_next.idx   = s2_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= tag.valid && !kill;
            s2_valid_reg <= s1_valid_reg && !kill;
            res_reg      <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_reg[k] <= mag_next[k];
            sq_reg[k]  <= SQ_W'(mag_reg[k]) * SQ_W'(mag_reg[k]);
        end
        s1_idx_reg <= tag.idx;
        s2_idx_reg <= s1_idx_reg;
    end

    assign res = res_reg;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the vertex weld and triangle remap block.
module testbench;
    import vwr_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 510;
    localparam int NUM_PHASES    = 6;
    localparam logic [TOL_W-1:0] TOL_MAX = '1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [CORNER_W-1:0]   corner_t;

    typedef struct {
        bit                  drain;
        logic [OPCODE_W-1:0] op;
        coord_t              px;
        coord_t              py;
        coord_t              pz;
        corner_t             ca;
        corner_t             cb;
        corner_t             cc;
    } mesh_item_t;

    typedef struct {
        kind_t                kind;
        logic                 is_new;
        logic [OUT_IDX_W-1:0] src;
        logic [OUT_IDX_W-1:0] wld;
        corner_t              ca;
        corner_t              cb;
        corner_t              cc;
    } weld_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OPCODE_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [TOL_W-1:0]      cfg_data = '0;

    coord_t           kept_x [MAX_VERTICES];
    coord_t           kept_y [MAX_VERTICES];
    coord_t           kept_z [MAX_VERTICES];
    int               weld_map [MAX_VERTICES];
    int               seen_vertices = 0;
    int               kept_vertices = 0;
    logic [TOL_W-1:0] tol_now = '0;

    mesh_item_t   mesh_feed_q [$];
    weld_result_t weld_results_q [$];
    mesh_item_t   offered_item;
    weld_result_t oldest_due;
    int           mismatches = 0;
    int           items_queued = 0;
    int           items_accepted = 0;
    int           rx_words = 0;
    int           hold_left = 0;

    vertex_weld_remap DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 50)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h, wanted %0h", name, got, want));
        end
    endtask

    function automatic coord_t rand_coord();
        return coord_t'($urandom());
    endfunction

    function automatic corner_t remap_corner(input corner_t c);
        if (c < seen_vertices)
        begin
            return corner_t'(weld_map[c]);
        end
        return c;
    endfunction

    task automatic predict_weld(input mesh_item_t it);
        weld_result_t res;
        longint       dx;
        longint       dy;
        longint       dz;
        longint       d2;
        int           idx;
        int           welded;
        bit           found;
        res.kind   = KIND_VERTEX;
        res.is_new = 1'b0;
        res.src    = '0;
        res.wld    = '0;
        res.ca     = '0;
        res.cb     = '0;
        res.cc     = '0;
        if (it.op == OP_START)
        begin
            seen_vertices = 0;
            kept_vertices = 0;
        end
        else if (it.op == OP_VERTEX)
        begin
            if (seen_vertices >= MAX_VERTICES)
            begin
                res.kind = KIND_OVERFLOW;
                weld_results_q = {weld_results_q, res};
            end
            else
            begin
                found  = 1'b0;
                welded = kept_vertices;
                idx    = 0;
                while (!found && idx < kept_vertices)
                begin
                    dx = longint'($signed(it.px)) - longint'($signed(kept_x[idx]));
                    dy = longint'($signed(it.py)) - longint'($signed(kept_y[idx]));
                    dz = longint'($signed(it.pz)) - longint'($signed(kept_z[idx]));
                    d2 = dx * dx + dy * dy + dz * dz;
                    if (d2 <= longint'(tol_now))
                    begin
                        found  = 1'b1;
                        welded = idx;
                    end
                    idx++;
                end
                if (!found)
                begin
                    kept_x[kept_vertices] = it.px;
                    kept_y[kept_vertices] = it.py;
                    kept_z[kept_vertices] = it.pz;
                    kept_vertices++;
                end
                weld_map[seen_vertices] = welded;
                res.is_new = !found;
                res.src    = seen_vertices[OUT_IDX_W-1:0];
                res.wld    = welded[OUT_IDX_W-1:0];
                seen_vertices++;
                weld_results_q = {weld_results_q, res};
            end
        end
        else if (it.op == OP_TRIANGLE)
        begin
            res.kind = KIND_TRIANGLE;
            res.ca   = remap_corner(it.ca);
            res.cb   = remap_corner(it.cb);
            res.cc   = remap_corner(it.cc);
            if (res.ca != res.cb && res.cb != res.cc && res.ca != res.cc)
            begin
                weld_results_q = {weld_results_q, res};
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_weld(offered_item);
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (mesh_feed_q.size() != 0 && mesh_feed_q[0].drain)
                begin
                    s_tvalid <= 1'b0;
                    if (weld_results_q.size() == 0)
                    begin
                        mesh_feed_q.delete(0);
                    end
                end
                else if (mesh_feed_q.size() != 0 &&
                         ((items_accepted >= 240 && items_accepted < 340) ||
                          $urandom_range(99) >= 13))
                begin
                    offered_item = mesh_feed_q.pop_front();
                    s_tdata  <= {offered_item.cc, offered_item.cb, offered_item.ca,
                                 offered_item.pz, offered_item.py, offered_item.px};
                    s_tuser  <= offered_item.op;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                rx_words++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (m_tvalid && m_tready && (rx_words == 150 || rx_words == 400))
            begin
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= (rx_words >= 240 && rx_words < 340) || ($urandom_range(99) >= 13);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (weld_results_q.size() == 0)
            begin
                report_mismatch("result word arrived with nothing outstanding");
            end
            else
            begin
                oldest_due = weld_results_q.pop_front();
                check_field("result_kind", 32'(m_tuser), 32'(oldest_due.kind));
                check_field("is_new_vertex", 32'(m_tdata[0]), 32'(oldest_due.is_new));
                check_field("source_index", 32'(m_tdata[10:1]), 32'(oldest_due.src));
                check_field("welded_index", 32'(m_tdata[20:11]), 32'(oldest_due.wld));
                check_field("out_corner_a", m_tdata[52:21], oldest_due.ca);
                check_field("out_corner_b", m_tdata[84:53], oldest_due.cb);
                check_field("out_corner_c", m_tdata[116:85], oldest_due.cc);
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic push_item(input logic [OPCODE_W-1:0] op, input coord_t x, input coord_t y,
                             input coord_t z, input corner_t a, input corner_t b,
                             input corner_t c);
        mesh_item_t it;
        it.drain = 1'b0;
        it.op    = op;
        it.px    = x;
        it.py    = y;
        it.pz    = z;
        it.ca    = a;
        it.cb    = b;
        it.cc    = c;
        mesh_feed_q = {mesh_feed_q, it};
        if (op != OP_UNUSED)
        begin
            items_queued++;
        end
    endtask

    task automatic push_vertex(input coord_t x, input coord_t y, input coord_t z);
        push_item(OP_VERTEX, x, y, z, $urandom(), $urandom(), $urandom());
    endtask

    task automatic push_triangle(input corner_t a, input corner_t b, input corner_t c);
        push_item(OP_TRIANGLE, rand_coord(), rand_coord(), rand_coord(), a, b, c);
    endtask

    task automatic push_start();
        push_item(OP_START, rand_coord(), rand_coord(), rand_coord(), $urandom(), $urandom(),
                  $urandom());
    endtask

    task automatic push_drain();
        mesh_item_t it;
        it = '{drain: 1'b1, op: OP_START, default: '0};
        mesh_feed_q = {mesh_feed_q, it};
    endtask

    function automatic coord_t jitter(input coord_t c, input longint r);
        longint off;
        if ($urandom_range(3) == 0)
        begin
            return c;
        end
        off = longint'($urandom_range(32'(2 * r))) - r;
        return c + off[COORD_BITS-1:0];
    endfunction

    function automatic coord_t pick_center();
        case ($urandom_range(7))
            0: return {1'b1, {(COORD_BITS-1){1'b0}}};
            1: return {1'b0, {(COORD_BITS-1){1'b1}}};
            default: return rand_coord();
        endcase
    endfunction

    function automatic corner_t pick_corner(input int n);
        case ($urandom_range(9))
            0: return $urandom();
            1: return corner_t'(n + $urandom_range(3));
            default: return corner_t'($urandom_range(n - 1));
        endcase
    endfunction

    task automatic gen_group(input int n_vert, input int n_tri);
        coord_t  cx [4];
        coord_t  cy [4];
        coord_t  cz [4];
        int      n_centers;
        int      pick;
        longint  r;
        corner_t a;
        r = 1;
        while (r * r * 3 < longint'(tol_now) && r < 4000000)
        begin
            r = r * 2;
        end
        if ($urandom_range(19) != 0)
        begin
            push_start();
        end
        n_centers = $urandom_range(4, 1);
        for (int i = 0; i < n_centers; i++)
        begin
            cx[i] = pick_center();
            cy[i] = pick_center();
            cz[i] = pick_center();
        end
        for (int v = 0; v < n_vert; v++)
        begin
            if ($urandom_range(29) == 0)
            begin
                push_item(OP_UNUSED, rand_coord(), rand_coord(), rand_coord(), $urandom(),
                          $urandom(), $urandom());
            end
            if ($urandom_range(29) == 0)
            begin
                push_triangle(pick_corner(v + 1), pick_corner(v + 1), pick_corner(v + 1));
            end
            pick = $urandom_range(n_centers - 1);
            if ($urandom_range(7) == 0)
            begin
                push_vertex(rand_coord(), rand_coord(), rand_coord());
            end
            else
            begin
                push_vertex(jitter(cx[pick], r), jitter(cy[pick], r), jitter(cz[pick], r));
            end
        end
        for (int t = 0; t < n_tri; t++)
        begin
            a = pick_corner(n_vert);
            if ($urandom_range(7) == 0)
            begin
                push_triangle(a, a, pick_corner(n_vert));
            end
            else
            begin
                push_triangle(a, pick_corner(n_vert), pick_corner(n_vert));
            end
        end
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tol_now = value;
    endtask

    task automatic settle();
        while (mesh_feed_q.size() != 0 || s_tvalid || weld_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [TOL_W-1:0] phase_tol [NUM_PHASES];
        int               quota;
        int               group_no;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_tolerance('0);
        push_start();
        push_vertex(24'h800000, 24'h800000, 24'h800000);
        push_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        push_vertex(24'h000000, 24'h000000, 24'h000000);
        push_vertex(24'h000000, 24'h000000, 24'h000000);
        push_vertex(24'h000001, 24'h000000, 24'h000000);
        push_triangle(0, 1, 2);
        push_triangle(3, 4, 0);
        push_triangle(2, 3, 1);
        push_triangle(5, 32'hFFFF_FFFF, 1);
        push_triangle(7, 7, 0);
        push_item(OP_UNUSED, rand_coord(), rand_coord(), rand_coord(), $urandom(), $urandom(),
                  $urandom());
        push_start();
        push_triangle(0, 1, 2);
        push_vertex(rand_coord(), rand_coord(), rand_coord());
        push_triangle(0, 32'h8000_0000, 0);
        settle();

        // Squared distance exactly at the tolerance welds, one above does not.
        write_tolerance(TOL_W'(1));
        push_start();
        push_vertex(24'h000000, 24'h000000, 24'h000000);
        push_vertex(24'h000001, 24'h000000, 24'h000000);
        push_vertex(24'h000001, 24'hFFFFFF, 24'h000000);
        push_triangle(0, 1, 2);
        settle();

        phase_tol[0] = '0;
        phase_tol[1] = TOL_W'(3);
        phase_tol[2] = TOL_W'($urandom_range(20000));
        phase_tol[3] = TOL_W'({$urandom(), $urandom()});
        phase_tol[4] = TOL_W'({$urandom_range(255), 32'h0}) + TOL_W'($urandom());
        phase_tol[5] = TOL_MAX;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_tolerance(phase_tol[p]);
            quota = items_queued + RANDOM_ITEMS / NUM_PHASES;
            group_no = 0;
            while (items_queued < quota)
            begin
                if ($urandom_range(11) == 0)
                begin
                    gen_group($urandom_range(120, 60), $urandom_range(10));
                end
                else
                begin
                    gen_group($urandom_range(24, 1), $urandom_range(10));
                end
                if (group_no == 1)
                begin
                    push_drain();
                end
                group_no++;
            end
            settle();
        end

        push_start();
        push_vertex(24'h800000, 24'h7FFFFF, 24'h000000);
        push_triangle(0, 1, 2);
        settle();

        if (mismatches == 0 && weld_results_q.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
